>>> hdl/zfw_pkg.sv
// ----------------------------------------------------------------------------
// zfw_pkg
// Shared types and constants for the Zstandard frame walker: transaction
// payloads, walker phases, event codes and the walker state record.
// ----------------------------------------------------------------------------
`default_nettype none

package zfw_pkg;

	// Frame magic numbers
	localparam logic [31:0] DATA_MAGIC      = 32'hFD2FB528;
	localparam logic [31:0] SKIP_MAGIC_BASE = 32'h184D2A50;
	localparam logic [31:0] SKIP_MAGIC_MASK = 32'hFFFFFFF0;

	// Field lengths in bytes
	localparam logic [3:0] MAGIC_BYTES    = 4'd4;
	localparam logic [3:0] BLKHDR_BYTES   = 4'd3;
	localparam logic [3:0] CHECKSUM_BYTES = 4'd4;
	localparam logic [3:0] SKIPLEN_BYTES  = 4'd4;

	// Window size = (8 + mantissa) << (WINDOW_SHIFT_BASE + exponent)
	localparam logic [5:0] WINDOW_SHIFT_BASE = 6'd7;

	// Block type carrying a single content byte
	localparam logic [1:0] BLK_RLE = 2'd1;

	// Two-byte content size is offset by this amount
	localparam logic [63:0] FCS2_OFFSET = 64'd256;

	// Walker phase; doubles as the byte role on the result
	typedef enum logic [3:0] {
		PH_MAGIC    = 4'd0,
		PH_DESC     = 4'd1,
		PH_WINDOW   = 4'd2,
		PH_DICT     = 4'd3,
		PH_FCS      = 4'd4,
		PH_BLKHDR   = 4'd5,
		PH_BLKDATA  = 4'd6,
		PH_CHECKSUM = 4'd7,
		PH_SKIPLEN  = 4'd8,
		PH_SKIPDATA = 4'd9,
		PH_ERROR    = 4'd10
	} phase_t;

	// Event reported with each byte
	typedef enum logic [3:0] {
		EV_NONE        = 4'd0,
		EV_FRAME_START = 4'd1,
		EV_WINDOW      = 4'd2,
		EV_DICT        = 4'd3,
		EV_FCS         = 4'd4,
		EV_BLOCK       = 4'd5,
		EV_FRAME_END   = 4'd6,
		EV_SKIP_END    = 4'd7,
		EV_BAD_MAGIC   = 4'd8,
		EV_TRUNCATED   = 4'd9
	} event_t;

	// Input transaction
	typedef struct packed {
		logic [7:0] byte_value;
		logic       stream_end;
	} byte_item_t;

	// Result transaction
	typedef struct packed {
		logic [3:0]  byte_role;
		logic [3:0]  event_res;
		logic [63:0] field_value;
		logic [1:0]  block_kind;
		logic        block_is_last;
		logic        has_checksum;
		logic [31:0] frames_seen;
		logic [31:0] blocks_seen;
	} res_item_t;

	// Walker state carried from byte to byte
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  idx;
		logic [63:0] acc;
		logic [31:0] skip;
		logic [1:0]  dict_code;
		logic        chk;
		logic        single_seg;
		logic [3:0]  cs_bytes;
		logic        last_blk;
		logic [31:0] frames;
		logic [31:0] blocks;
	} walk_state_t;

	localparam walk_state_t WALK_RESET = '{
		phase:      PH_MAGIC,
		idx:        4'd0,
		acc:        64'd0,
		skip:       32'd0,
		dict_code:  2'd0,
		chk:        1'b0,
		single_seg: 1'b0,
		cs_bytes:   4'd0,
		last_blk:   1'b0,
		frames:     32'd0,
		blocks:     32'd0
	};

endpackage

`default_nettype wire

>>> hdl/zfw_step.sv
// ----------------------------------------------------------------------------
// zfw_step
// Per-byte walker update: from the current state and one stream byte,
// produces the next state and the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module zfw_step (
	input  wire zfw_pkg::walk_state_t cur,
	input  wire zfw_pkg::byte_item_t  item,
	output zfw_pkg::walk_state_t      nxt,
	output zfw_pkg::res_item_t        res
);

	// First optional header field after the one just finished
	function automatic zfw_pkg::phase_t next_hdr(
		input zfw_pkg::phase_t done,
		input logic            ss,
		input logic [1:0]      dc,
		input logic [3:0]      csb
	);
		zfw_pkg::phase_t p;
		priority if (done < zfw_pkg::PH_WINDOW && !ss)
			p = zfw_pkg::PH_WINDOW;
		else if (done < zfw_pkg::PH_DICT && dc != 2'd0)
			p = zfw_pkg::PH_DICT;
		else if (done < zfw_pkg::PH_FCS && csb != 4'd0)
			p = zfw_pkg::PH_FCS;
		else
			p = zfw_pkg::PH_BLKHDR;
		return p;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	logic [7:0]        b;
	logic [63:0]       acc_col;
	logic [3:0]        idx_inc;
	logic [31:0]       skip_dec;
	logic [31:0]       magic;
	logic [28:0]       blk_len;
	logic [1:0]        blk_type;
	logic [3:0]        want_dict;
	logic [3:0]        csb_new;
	logic              eob;
	zfw_pkg::phase_t   role;
	zfw_pkg::event_t   ev;
	logic [63:0]       val;
	logic [1:0]        kind;
	logic              last;

	assign b        = item.byte_value;
	assign acc_col  = cur.acc | ({56'd0, b} << {cur.idx[2:0], 3'b000});
	assign idx_inc  = cur.idx + 4'd1;
	assign skip_dec = (cur.skip != 32'd0) ? cur.skip - 32'd1 : cur.skip;
	assign magic    = acc_col[31:0];
	assign blk_len  = acc_col[31:3];
	assign blk_type = acc_col[2:1];

	// Dictionary id length from its size code
	always_comb begin
		unique case (cur.dict_code)
			2'd1:    want_dict = 4'd1;
			2'd2:    want_dict = 4'd2;
			2'd3:    want_dict = 4'd4;
			default: want_dict = 4'd8;
		endcase
	end

	// Content size length from the descriptor byte
	always_comb begin
		unique case (b[7:6])
			2'd0:    csb_new = b[5] ? 4'd1 : 4'd0;
			2'd1:    csb_new = 4'd2;
			2'd2:    csb_new = 4'd4;
			default: csb_new = 4'd8;
		endcase
	end

	// Phase update
	always_comb begin
		nxt  = cur;
		role = cur.phase;
		ev   = zfw_pkg::EV_NONE;
		val  = 64'd0;
		kind = 2'd0;
		last = 1'b0;
		eob  = 1'b0;

		unique case (cur.phase)
			zfw_pkg::PH_MAGIC: begin
				if (idx_inc >= zfw_pkg::MAGIC_BYTES) begin
					nxt.idx = 4'd0;
					nxt.acc = 64'd0;
					val     = {32'd0, magic};
					if (magic == zfw_pkg::DATA_MAGIC ||
					    (magic & zfw_pkg::SKIP_MAGIC_MASK) == zfw_pkg::SKIP_MAGIC_BASE) begin
						ev         = zfw_pkg::EV_FRAME_START;
						nxt.frames = sat_inc(cur.frames);
						nxt.chk    = 1'b0;
						nxt.phase  = (magic == zfw_pkg::DATA_MAGIC) ?
							zfw_pkg::PH_DESC : zfw_pkg::PH_SKIPLEN;
					end else begin
						ev        = zfw_pkg::EV_BAD_MAGIC;
						nxt.phase = zfw_pkg::PH_ERROR;
					end
				end else begin
					nxt.idx = idx_inc;
					nxt.acc = acc_col;
				end
			end
			zfw_pkg::PH_DESC: begin
				nxt.dict_code  = b[1:0];
				nxt.chk        = b[2];
				nxt.single_seg = b[5];
				nxt.cs_bytes   = csb_new;
				nxt.idx        = 4'd0;
				nxt.acc        = 64'd0;
				nxt.phase      = next_hdr(zfw_pkg::PH_DESC, b[5], b[1:0], csb_new);
			end
			zfw_pkg::PH_WINDOW: begin
				val = {60'd0, 1'b1, b[2:0]} << ({1'b0, b[7:3]} + zfw_pkg::WINDOW_SHIFT_BASE);
				ev  = zfw_pkg::EV_WINDOW;
				nxt.idx   = 4'd0;
				nxt.acc   = 64'd0;
				nxt.phase = next_hdr(zfw_pkg::PH_WINDOW, cur.single_seg, cur.dict_code,
					cur.cs_bytes);
			end
			zfw_pkg::PH_DICT: begin
				if (idx_inc >= want_dict) begin
					val       = acc_col;
					ev        = zfw_pkg::EV_DICT;
					nxt.idx   = 4'd0;
					nxt.acc   = 64'd0;
					nxt.phase = next_hdr(zfw_pkg::PH_DICT, cur.single_seg, cur.dict_code,
						cur.cs_bytes);
				end else begin
					nxt.idx = idx_inc;
					nxt.acc = acc_col;
				end
			end
			zfw_pkg::PH_FCS: begin
				if (idx_inc >= cur.cs_bytes) begin
					val = acc_col + ((cur.cs_bytes == 4'd2) ? zfw_pkg::FCS2_OFFSET : 64'd0);
					ev        = zfw_pkg::EV_FCS;
					nxt.idx   = 4'd0;
					nxt.acc   = 64'd0;
					nxt.phase = zfw_pkg::PH_BLKHDR;
				end else begin
					nxt.idx = idx_inc;
					nxt.acc = acc_col;
				end
			end
			zfw_pkg::PH_BLKHDR: begin
				if (idx_inc >= zfw_pkg::BLKHDR_BYTES) begin
					last         = acc_col[0];
					kind         = blk_type;
					val          = {35'd0, blk_len};
					ev           = zfw_pkg::EV_BLOCK;
					nxt.blocks   = sat_inc(cur.blocks);
					nxt.last_blk = acc_col[0];
					nxt.skip     = (blk_type == zfw_pkg::BLK_RLE) ? 32'd1 : {3'd0, blk_len};
					nxt.idx      = 4'd0;
					nxt.acc      = 64'd0;
					if (nxt.skip != 32'd0)
						nxt.phase = zfw_pkg::PH_BLKDATA;
					else
						eob = 1'b1;
				end else begin
					nxt.idx = idx_inc;
					nxt.acc = acc_col;
				end
			end
			zfw_pkg::PH_BLKDATA: begin
				nxt.skip = skip_dec;
				if (skip_dec == 32'd0)
					eob = 1'b1;
			end
			zfw_pkg::PH_CHECKSUM: begin
				nxt.idx = idx_inc;
				if (idx_inc >= zfw_pkg::CHECKSUM_BYTES) begin
					nxt.idx   = 4'd0;
					nxt.acc   = 64'd0;
					ev        = zfw_pkg::EV_FRAME_END;
					nxt.phase = zfw_pkg::PH_MAGIC;
				end
			end
			zfw_pkg::PH_SKIPLEN: begin
				if (idx_inc >= zfw_pkg::SKIPLEN_BYTES) begin
					nxt.skip = acc_col[31:0];
					nxt.idx  = 4'd0;
					nxt.acc  = 64'd0;
					if (acc_col[31:0] == 32'd0) begin
						ev        = zfw_pkg::EV_SKIP_END;
						nxt.phase = zfw_pkg::PH_MAGIC;
					end else begin
						nxt.phase = zfw_pkg::PH_SKIPDATA;
					end
				end else begin
					nxt.idx = idx_inc;
					nxt.acc = acc_col;
				end
			end
			zfw_pkg::PH_SKIPDATA: begin
				nxt.skip = skip_dec;
				if (skip_dec == 32'd0) begin
					ev        = zfw_pkg::EV_SKIP_END;
					nxt.phase = zfw_pkg::PH_MAGIC;
				end
			end
			default: begin
				// error phase and unused codes: sticky error
				role      = zfw_pkg::PH_ERROR;
				nxt.phase = zfw_pkg::PH_ERROR;
			end
		endcase

		// End of a block: next header, checksum or end of frame
		if (eob) begin
			nxt.idx = 4'd0;
			nxt.acc = 64'd0;
			priority if (!nxt.last_blk) begin
				nxt.phase = zfw_pkg::PH_BLKHDR;
			end else if (nxt.chk) begin
				nxt.phase = zfw_pkg::PH_CHECKSUM;
			end else begin
				ev        = zfw_pkg::EV_FRAME_END;
				nxt.phase = zfw_pkg::PH_MAGIC;
			end
		end

		// Stream ends inside a frame or a partial magic
		if (item.stream_end && nxt.phase != zfw_pkg::PH_ERROR &&
		    (nxt.phase != zfw_pkg::PH_MAGIC || nxt.idx != 4'd0)) begin
			ev        = zfw_pkg::EV_TRUNCATED;
			val       = 64'd0;
			nxt.phase = zfw_pkg::PH_ERROR;
		end
	end

	// Result transaction
	always_comb begin
		res.byte_role     = role;
		res.event_res     = ev;
		res.field_value   = val;
		res.block_kind    = kind;
		res.block_is_last = last;
		res.has_checksum  = nxt.chk;
		res.frames_seen   = nxt.frames;
		res.blocks_seen   = nxt.blocks;
	end

endmodule

`default_nettype wire

>>> hdl/zstd_frame_walker_core.sv
// ----------------------------------------------------------------------------
// zstd_frame_walker_core
// Zstandard frame and block header walker, one stream byte per transaction.
// ----------------------------------------------------------------------------
// Takes one byte of a compressed stream per cycle unless the result is
// stalled and returns one result per byte: its role in the framing, any
// decoded header event with its value, the block fields, the checksum flag
// and saturating frame and block counts. An accepted byte sits in the input
// register; once the result register is free, the walker state is updated
// and the result register is loaded from that byte. The rate is set by the
// walker state register, which is updated once per byte by a single short
// step. A stalled result holds the input register, which then stalls the input.
// A bad magic number or a stream that ends inside a frame stops the walker
// until reset; every later byte reports the after-error role.
`default_nettype none

module zstd_frame_walker_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    byte_valid,
	output logic                   byte_stall,
	input  wire zfw_pkg::byte_item_t byte_item,
	output logic                   res_valid,
	input  wire                    res_stall,
	output zfw_pkg::res_item_t     res_item
);

	logic                 valid_s1;
	zfw_pkg::byte_item_t  item_s1;
	zfw_pkg::walk_state_t state_q;
	zfw_pkg::walk_state_t state_nxt;
	zfw_pkg::res_item_t   res_nxt;
	logic                 res_valid_q;
	zfw_pkg::res_item_t   res_q;
	logic                 adv_s1;
	logic                 take_in;

	// Handshake: input register moves when the result register is free
	assign adv_s1     = valid_s1 && (!res_valid_q || !res_stall);
	assign byte_stall = valid_s1 && res_valid_q && res_stall;
	assign take_in    = byte_valid && !byte_stall;

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	zfw_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Control and walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= zfw_pkg::WALK_RESET;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;

			if (adv_s1)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;

			if (adv_s1)
				state_q <= state_nxt;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take_in)
			item_s1 <= byte_item;
		if (adv_s1)
			res_q <= res_nxt;
	end

endmodule

`default_nettype wire
